@@ hdl/rfgm_pkg.sv @@
package rfgm_pkg;

  // Sizing of the queues.
  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int ROLE_COUNT  = 3;

  // Fixed widths of the ports.
  localparam int KIND_BITS   = 2;
  localparam int ROLE_BITS   = 2;
  localparam int FIELD_BITS  = 16;
  localparam int STATUS_BITS = 2;
  localparam int TOTAL_BITS  = 6;
  localparam int TOTAL_MAX   = 63;

  // Fill counter must hold the depth itself.
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  // Sum of the three counters, never narrower than the total field.
  localparam int SUM_W = (CNT_W + 2 > TOTAL_BITS) ? CNT_W + 2 : TOTAL_BITS;

  // Operation codes of the kind field.
  localparam logic [KIND_BITS-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_POP   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_GROUP = 2'd2;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd2;

  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [CNT_W-1:0]       count_t;

  // Per-queue command for one cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  // Controls seen by one storage cell.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic handle_t to_handle(input logic [FIELD_BITS-1:0] field);
    handle_t h;
    for (int b = 0; b < HANDLE_BITS; b++) begin
      h[b] = (b < FIELD_BITS) ? field[b] : 1'b0;
    end
    return h;
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input handle_t h);
    logic [FIELD_BITS-1:0] f;
    for (int b = 0; b < FIELD_BITS; b++) begin
      f[b] = (b < HANDLE_BITS) ? h[b] : 1'b0;
    end
    return f;
  endfunction

endpackage

@@ hdl/rfgm_cell.sv @@
// One slot of a role queue: loads a pushed handle when it sits at the tail,
// and takes its neighbour's handle when the queue advances.
module rfgm_cell (
  input  logic                clk_i,
  input  rfgm_pkg::cell_ctrl_t ctrl_i,
  input  rfgm_pkg::handle_t   push_data_i,
  input  rfgm_pkg::handle_t   next_data_i,
  output rfgm_pkg::handle_t   data_o
);

  rfgm_pkg::handle_t data_q;
  rfgm_pkg::handle_t data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = push_data_i;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hdl/rfgm_queue.sv @@
// One role queue as a row of cells; cell zero always holds the front.
module rfgm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfgm_pkg::q_cmd_t    cmd_i,
  input  rfgm_pkg::handle_t   push_data_i,
  output rfgm_pkg::count_t    count_o,
  output rfgm_pkg::handle_t   front_o
);

  rfgm_pkg::count_t  count_q;
  rfgm_pkg::count_t  count_d;
  rfgm_pkg::handle_t cell_data [rfgm_pkg::QUEUE_DEPTH];

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + rfgm_pkg::count_t'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - rfgm_pkg::count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar i = 0; i < rfgm_pkg::QUEUE_DEPTH; i++) begin : g_cell
    rfgm_pkg::cell_ctrl_t ctrl;
    rfgm_pkg::handle_t    next_data;

    assign ctrl.load  = cmd_i.push && (count_q == rfgm_pkg::count_t'(i));
    assign ctrl.shift = cmd_i.pop;

    if (i == rfgm_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    rfgm_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .push_data_i (push_data_i),
      .next_data_i (next_data),
      .data_o      (cell_data[i])
    );
  end

  assign count_o = count_q;
  assign front_o = cell_data[0];

endmodule

@@ hdl/role_fifo_group_matcher.sv @@
// Role queue group matcher. Three first-in-first-out queues of player
// handles (defender, hunter, bard) take one command word per clock cycle:
// push a handle, pop the front of one role, or pop a whole group. A word is
// taken at a rising edge where start is high and busy is low; busy is high
// from reset until the first rising edge after it and low from then on, so
// a new word may follow in every cycle. The result word appears on the
// result ports in the cycle after the command is taken, for exactly one
// cycle, marked by result_valid_o; the receiver cannot stall it, so it must
// capture the word in that cycle. Each queue is a row of cells that shifts
// forward on a pop and loads at the tail on a push, all within the
// accepting edge.
module role_fifo_group_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  role_i,
  input  logic [15:0] player_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [5:0]  total_held_o,
  output logic        group_ready_o,
  output logic [15:0] defender_front_o,
  output logic        defender_valid_o,
  output logic [15:0] hunter_front_o,
  output logic        hunter_valid_o,
  output logic [15:0] bard_front_o,
  output logic        bard_valid_o
);

  localparam int RC = rfgm_pkg::ROLE_COUNT;

  logic busy_q;
  logic valid_q;
  logic valid_d;
  logic [rfgm_pkg::STATUS_BITS-1:0] status_q;
  logic [rfgm_pkg::STATUS_BITS-1:0] status_d;

  logic              accept;
  rfgm_pkg::q_cmd_t  cmd     [RC];
  rfgm_pkg::count_t  count   [RC];
  rfgm_pkg::handle_t front   [RC];
  logic [RC-1:0]     nonempty;
  logic [RC-1:0]     role_hit;
  logic [RC-1:0]     can_push;
  logic              all_ready;
  rfgm_pkg::handle_t push_data;
  logic [rfgm_pkg::SUM_W-1:0] total_sum;
  logic [rfgm_pkg::FIELD_BITS-1:0] front_field [RC];

  assign accept    = start && !busy_q;
  assign push_data = rfgm_pkg::to_handle(player_i);

  for (genvar q = 0; q < RC; q++) begin : g_flags
    assign nonempty[q] = (count[q] != '0);
    assign role_hit[q] = (role_i == rfgm_pkg::ROLE_BITS'(q));
    assign can_push[q] = (count[q] != rfgm_pkg::count_t'(rfgm_pkg::QUEUE_DEPTH));
  end

  assign all_ready = &nonempty;

  // Decode the command into per-queue push and pop requests. A role code
  // with no queue behind it matches nothing and so reports the failure.
  always_comb begin
    status_d = rfgm_pkg::ST_DONE;
    for (int q = 0; q < RC; q++) begin
      cmd[q] = '0;
    end
    if (accept) begin
      case (kind_i)
        rfgm_pkg::KIND_PUSH: begin
          if ((role_hit & can_push) != '0) begin
            for (int q = 0; q < RC; q++) begin
              cmd[q].push = role_hit[q];
            end
          end else begin
            status_d = rfgm_pkg::ST_DROPPED;
          end
        end
        rfgm_pkg::KIND_POP: begin
          if ((role_hit & nonempty) != '0) begin
            for (int q = 0; q < RC; q++) begin
              cmd[q].pop = role_hit[q];
            end
          end else begin
            status_d = rfgm_pkg::ST_EMPTY;
          end
        end
        rfgm_pkg::KIND_GROUP: begin
          if (all_ready) begin
            for (int q = 0; q < RC; q++) begin
              cmd[q].pop = 1'b1;
            end
          end else begin
            status_d = rfgm_pkg::ST_EMPTY;
          end
        end
        default: begin
          // The spare kind code is a no-operation that still reports done.
          status_d = rfgm_pkg::ST_DONE;
        end
      endcase
    end
  end

  for (genvar q = 0; q < RC; q++) begin : g_queue
    rfgm_queue u_queue (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd[q]),
      .push_data_i (push_data),
      .count_o     (count[q]),
      .front_o     (front[q])
    );
    // An empty queue reports a zero front whatever its cells hold.
    assign front_field[q] = nonempty[q] ? rfgm_pkg::to_field(front[q]) : '0;
  end

  assign valid_d = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= 1'b0;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  // The state fields are read straight from the queues, which only change
  // on an accepted word, so they line up with the registered status.
  always_comb begin
    total_sum = '0;
    for (int q = 0; q < RC; q++) begin
      total_sum = total_sum + rfgm_pkg::SUM_W'(count[q]);
    end
  end

  assign total_held_o = (total_sum > rfgm_pkg::SUM_W'(rfgm_pkg::TOTAL_MAX))
                        ? rfgm_pkg::TOTAL_BITS'(rfgm_pkg::TOTAL_MAX)
                        : total_sum[rfgm_pkg::TOTAL_BITS-1:0];

  assign busy             = busy_q;
  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign group_ready_o    = all_ready;
  assign defender_front_o = front_field[0];
  assign defender_valid_o = nonempty[0];
  assign hunter_front_o   = front_field[1];
  assign hunter_valid_o   = nonempty[1];
  assign bard_front_o     = front_field[2];
  assign bard_valid_o     = nonempty[2];

endmodule

@@ test/role_fifo_group_matcher_tb.sv @@
`timescale 1ns / 100ps

module role_fifo_group_matcher_tb;

  // The kind field has one code that the package leaves unnamed: it does
  // nothing and still reports.
  localparam logic [rfgm_pkg::KIND_BITS-1:0] KIND_NOP = 2'd3;

  // Role codes. The fourth code selects no queue at all.
  localparam logic [rfgm_pkg::ROLE_BITS-1:0] ROLE_DEFENDER = 2'd0;
  localparam logic [rfgm_pkg::ROLE_BITS-1:0] ROLE_HUNTER   = 2'd1;
  localparam logic [rfgm_pkg::ROLE_BITS-1:0] ROLE_BARD     = 2'd2;
  localparam logic [rfgm_pkg::ROLE_BITS-1:0] ROLE_NONE     = 2'd3;

  // Number of random command words after the directed opening.
  localparam int RANDOM_WORDS = 500;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Cycles left after the last report, to catch any stray report.
  localparam int TAIL_CYCLES = 4;
  // Chance in a hundred that the sender leaves a cycle empty.
  localparam int GAP_PERCENT = 7;
  // Span of accepted words in which the sender leaves no random gap.
  localparam int STEADY_FIRST = 200;
  localparam int STEADY_LAST  = 330;

  // One command word as the sender holds it. drain_first makes the sender
  // wait until every outstanding report has come before offering it.
  typedef struct packed {
    logic [rfgm_pkg::KIND_BITS-1:0]  kind;
    logic [rfgm_pkg::ROLE_BITS-1:0]  role;
    logic [rfgm_pkg::FIELD_BITS-1:0] player;
    logic                            drain_first;
  } command_word_t;

  // One report word, as the block puts it on its result ports.
  typedef struct packed {
    logic [rfgm_pkg::STATUS_BITS-1:0]                         status;
    logic [rfgm_pkg::TOTAL_BITS-1:0]                          total;
    logic                                                     group_ready;
    logic [rfgm_pkg::ROLE_COUNT-1:0][rfgm_pkg::FIELD_BITS-1:0] front;
    logic [rfgm_pkg::ROLE_COUNT-1:0]                          valid;
  } queue_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind_i = '0;
  logic [1:0] role_i = '0;
  logic [15:0] player_i = '0;
  logic result_valid_o;
  logic [1:0] status_o;
  logic [5:0] total_held_o;
  logic group_ready_o;
  logic [15:0] defender_front_o;
  logic defender_valid_o;
  logic [15:0] hunter_front_o;
  logic hunter_valid_o;
  logic [15:0] bard_front_o;
  logic bard_valid_o;

  command_word_t pending_words[$];
  queue_report_t due_reports[$];

  // Set at a rising edge where the offered word was taken; the sender reads
  // it at the following falling edge to move on to the next word.
  logic word_taken = 1'b0;
  int sent_count = 0;
  int stall_cycles = 0;
  int error_count = 0;

  // Predictor state: one ring per role, with its front, next free slot and
  // fill level. Only slots that have been written are ever read back.
  rfgm_pkg::handle_t ring_slots [rfgm_pkg::ROLE_COUNT][rfgm_pkg::QUEUE_DEPTH];
  int unsigned ring_head [rfgm_pkg::ROLE_COUNT] = '{default: 0};
  int unsigned ring_tail [rfgm_pkg::ROLE_COUNT] = '{default: 0};
  int unsigned ring_fill [rfgm_pkg::ROLE_COUNT] = '{default: 0};

  role_fifo_group_matcher u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .role_i           (role_i),
    .player_i         (player_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .total_held_o     (total_held_o),
    .group_ready_o    (group_ready_o),
    .defender_front_o (defender_front_o),
    .defender_valid_o (defender_valid_o),
    .hunter_front_o   (hunter_front_o),
    .hunter_valid_o   (hunter_valid_o),
    .bard_front_o     (bard_front_o),
    .bard_valid_o     (bard_valid_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Applies one command word to the predictor state and returns the report
  // that the block must give for it. Every reported value is taken after
  // the update.
  function automatic queue_report_t apply_command(
      input logic [rfgm_pkg::KIND_BITS-1:0] kind,
      input logic [rfgm_pkg::ROLE_BITS-1:0] role,
      input logic [rfgm_pkg::FIELD_BITS-1:0] player);
    queue_report_t rep;
    int unsigned sum;
    logic all_held;
    rep = '0;
    rep.status = rfgm_pkg::ST_DONE;
    case (kind)
      rfgm_pkg::KIND_PUSH: begin
        // A push to the fourth role or to a full ring is dropped.
        if (role >= rfgm_pkg::ROLE_COUNT) begin
          rep.status = rfgm_pkg::ST_DROPPED;
        end else if (ring_fill[role] >= rfgm_pkg::QUEUE_DEPTH) begin
          rep.status = rfgm_pkg::ST_DROPPED;
        end else begin
          ring_slots[role][ring_tail[role]] = rfgm_pkg::handle_t'(player);
          ring_tail[role] = (ring_tail[role] + 1) % rfgm_pkg::QUEUE_DEPTH;
          ring_fill[role]++;
        end
      end
      rfgm_pkg::KIND_POP: begin
        if (role >= rfgm_pkg::ROLE_COUNT) begin
          rep.status = rfgm_pkg::ST_EMPTY;
        end else if (ring_fill[role] == 0) begin
          rep.status = rfgm_pkg::ST_EMPTY;
        end else begin
          ring_head[role] = (ring_head[role] + 1) % rfgm_pkg::QUEUE_DEPTH;
          ring_fill[role]--;
        end
      end
      rfgm_pkg::KIND_GROUP: begin
        // The role field plays no part in a group pop; it takes one from
        // every ring, or nothing at all if any ring is empty.
        all_held = 1'b1;
        for (int r = 0; r < rfgm_pkg::ROLE_COUNT; r++) begin
          if (ring_fill[r] == 0) all_held = 1'b0;
        end
        if (!all_held) begin
          rep.status = rfgm_pkg::ST_EMPTY;
        end else begin
          for (int r = 0; r < rfgm_pkg::ROLE_COUNT; r++) begin
            ring_head[r] = (ring_head[r] + 1) % rfgm_pkg::QUEUE_DEPTH;
            ring_fill[r]--;
          end
        end
      end
      default: begin
      end
    endcase

    sum = 0;
    rep.group_ready = 1'b1;
    for (int r = 0; r < rfgm_pkg::ROLE_COUNT; r++) begin
      sum += ring_fill[r];
      if (ring_fill[r] == 0) begin
        rep.group_ready = 1'b0;
        rep.front[r] = '0;
        rep.valid[r] = 1'b0;
      end else begin
        rep.front[r] = rfgm_pkg::FIELD_BITS'(ring_slots[r][ring_head[r]]);
        rep.valid[r] = 1'b1;
      end
    end
    rep.total = (sum > rfgm_pkg::TOTAL_MAX) ? rfgm_pkg::TOTAL_BITS'(rfgm_pkg::TOTAL_MAX)
                                            : rfgm_pkg::TOTAL_BITS'(sum);
    return rep;
  endfunction

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  task automatic add_word(input logic [rfgm_pkg::KIND_BITS-1:0] kind,
                          input logic [rfgm_pkg::ROLE_BITS-1:0] role,
                          input logic [rfgm_pkg::FIELD_BITS-1:0] player,
                          input logic drain_first);
    command_word_t w;
    w.kind = kind;
    w.role = role;
    w.player = player;
    w.drain_first = drain_first;
    pending_words.push_back(w);
  endtask

  // Sender. Everything changes at the falling edge, so the block sees
  // stable inputs at the rising edge. Once a word is offered it stays on the
  // ports until taken; gaps are only left between words. While start is
  // low the fields carry noise, which the block must ignore.
  always @(negedge clk_i) begin : drive_words
    logic offer;
    logic may_gap;
    if (rst_ni) begin
      if (word_taken) begin
        void'(pending_words.pop_front());
        sent_count++;
      end
      offer = 1'b0;
      if (pending_words.size() != 0) begin
        may_gap = !(sent_count >= STEADY_FIRST && sent_count < STEADY_LAST);
        if (start && !word_taken) begin
          offer = 1'b1;
        end else if (pending_words[0].drain_first && due_reports.size() != 0) begin
          offer = 1'b0;
        end else if (may_gap && $urandom_range(0, 99) < GAP_PERCENT) begin
          offer = 1'b0;
        end else begin
          offer = 1'b1;
        end
      end
      start <= offer;
      if (offer) begin
        kind_i <= pending_words[0].kind;
        role_i <= pending_words[0].role;
        player_i <= pending_words[0].player;
      end else begin
        kind_i <= 2'($urandom);
        role_i <= 2'($urandom);
        player_i <= 16'($urandom);
      end
    end
  end

  // Monitor. At each rising edge the report on the ports, if marked, is
  // matched against the oldest due report, and a word taken at this edge
  // is run through the predictor. The report for a word always comes at a
  // later edge than the word itself, so the order of the two steps here
  // does not matter.
  always @(posedge clk_i) begin : watch_reports
    queue_report_t want;
    logic moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (result_valid_o) begin
        moved = 1'b1;
        if (due_reports.size() == 0) begin
          error_count++;
          $display("%0t ns: report with none due, status %0h, total %0d", $time,
                   status_o, total_held_o);
        end else begin
          want = due_reports.pop_front();
          check_field("status", 16'(want.status), 16'(status_o));
          check_field("total_held", 16'(want.total), 16'(total_held_o));
          check_field("group_ready", 16'(want.group_ready), 16'(group_ready_o));
          check_field("defender_front", want.front[ROLE_DEFENDER], defender_front_o);
          check_field("defender_valid", 16'(want.valid[ROLE_DEFENDER]), 16'(defender_valid_o));
          check_field("hunter_front", want.front[ROLE_HUNTER], hunter_front_o);
          check_field("hunter_valid", 16'(want.valid[ROLE_HUNTER]), 16'(hunter_valid_o));
          check_field("bard_front", want.front[ROLE_BARD], bard_front_o);
          check_field("bard_valid", 16'(want.valid[ROLE_BARD]), 16'(bard_valid_o));
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        due_reports.push_back(apply_command(kind_i, role_i, player_i));
      end
      word_taken <= start && !busy;
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : run_test
    int push_bias;
    int pick;
    logic [rfgm_pkg::ROLE_BITS-1:0] role_pick;

    // Directed opening. Everything starts empty, so pops of every kind find
    // nothing; role three has no queue to push to or pop from.
    add_word(rfgm_pkg::KIND_GROUP, ROLE_DEFENDER, 16'h0000, 1'b0);
    add_word(rfgm_pkg::KIND_POP, ROLE_DEFENDER, 16'hFFFF, 1'b0);
    add_word(rfgm_pkg::KIND_POP, ROLE_NONE, 16'h0000, 1'b0);
    add_word(rfgm_pkg::KIND_PUSH, ROLE_NONE, 16'hFFFF, 1'b0);
    add_word(KIND_NOP, ROLE_NONE, 16'hFFFF, 1'b0);
    // One of each role makes a group; the group pop then ignores its role.
    add_word(rfgm_pkg::KIND_PUSH, ROLE_DEFENDER, 16'h0000, 1'b0);
    add_word(rfgm_pkg::KIND_PUSH, ROLE_HUNTER, 16'hFFFF, 1'b0);
    add_word(rfgm_pkg::KIND_PUSH, ROLE_BARD, 16'hA5A5, 1'b0);
    add_word(rfgm_pkg::KIND_GROUP, ROLE_NONE, 16'h5A5A, 1'b0);
    // Fill the bard ring to the brim, then one push too many. The first of
    // these waits for the line to drain.
    for (int i = 0; i <= rfgm_pkg::QUEUE_DEPTH; i++) begin
      add_word(rfgm_pkg::KIND_PUSH, ROLE_BARD, (i % 2 == 0) ? 16'hFFFF : 16'h0000, i == 0);
    end

    // Random part. The mix of pushes and pops shifts every forty words, so
    // that rings swing between full and empty.
    push_bias = 50;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_bias = 85;
          1: push_bias = 50;
          default: push_bias = 15;
        endcase
      end
      pick = $urandom_range(0, 99);
      role_pick = ($urandom_range(0, 99) < 4) ? ROLE_NONE : 2'($urandom_range(0, 2));
      if (pick < 3) begin
        add_word(KIND_NOP, 2'($urandom), 16'($urandom), i == 250);
      end else if (pick < push_bias) begin
        add_word(rfgm_pkg::KIND_PUSH, role_pick, 16'($urandom), i == 250);
      end else if ($urandom_range(0, 99) < 55) begin
        add_word(rfgm_pkg::KIND_POP, role_pick, 16'($urandom), i == 250);
      end else begin
        add_word(rfgm_pkg::KIND_GROUP, 2'($urandom), 16'($urandom), i == 250);
      end
    end

    // Reset is released at a falling edge, away from the sampling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_words.size() != 0 || due_reports.size() != 0)
           && stall_cycles < STALL_LIMIT) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (due_reports.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d reports still due at the end", $time, due_reports.size());
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, stall_cycles);
      $display("CHECK FAILED");
    end else if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ role_fifo_group_matcher.f @@
hdl/rfgm_pkg.sv
hdl/rfgm_cell.sv
hdl/rfgm_queue.sv
hdl/role_fifo_group_matcher.sv
test/role_fifo_group_matcher_tb.sv
